FILE: src/mbps_pkg.sv
// Package with the word types and register indexes of the masked byte pattern search.
`timescale 1ns / 1ps

package mbps_pkg;

    localparam int CFG_DATA_W  = 64;
    localparam int CFG_INDEX_W = 3;
    localparam int ADDR_W      = 32;
    localparam int LEN_CFG_W   = 5;
    localparam int PAT_BYTES   = 16;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_PATTERN_LOW     = 3'd0,
        REG_PATTERN_HIGH    = 3'd1,
        REG_MASK_LOW        = 3'd2,
        REG_MASK_HIGH       = 3'd3,
        REG_PATTERN_LENGTH  = 3'd4,
        REG_USE_MASK        = 3'd5,
        REG_SEARCH_BACKWARD = 3'd6,
        REG_REGION_BASE     = 3'd7
    } cfg_index_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_word_t;

    typedef struct packed {
        logic              found;
        logic [ADDR_W-1:0] match_address;
    } out_word_t;

endpackage

FILE: src/mbps_match.sv
// Byte window shift register and masked pattern comparators.
`timescale 1ns / 1ps

module mbps_match #(
    parameter int PATTERN_MAX = 16,
    parameter int LEN_W       = 5
) (
    input  logic                          aclk,
    input  logic                          shift_en,
    input  logic [7:0]                    data_byte,
    input  logic [8*mbps_pkg::PAT_BYTES-1:0] pattern,
    input  logic [8*mbps_pkg::PAT_BYTES-1:0] mask,
    input  logic                          use_mask,
    input  logic [LEN_W-1:0]              len,
    output logic                          hit
);
    import mbps_pkg::*;

    localparam int IDX_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

    // Entry 0 holds the newest byte.
    logic [7:0] window_reg  [PATTERN_MAX];
    logic [7:0] window_next [PATTERN_MAX];

    always_comb begin
        window_next[0] = data_byte;
        for (int k = 1; k < PATTERN_MAX; k++) begin
            window_next[k] = window_reg[k-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            window_reg <= window_next;
        end
    end

    // Pattern byte i lines up with the byte that arrived len-1-i bytes ago,
    // so the newest byte meets the last pattern byte.
    always_comb begin
        logic [LEN_W-1:0] pos;
        logic [7:0]       p;
        logic [7:0]       b;
        logic [7:0]       m;
        hit = 1'b1;
        for (int i = 0; i < PATTERN_MAX; i++) begin
            pos = len - LEN_W'(1) - LEN_W'(i);
            p   = pattern[8*i +: 8];
            m   = use_mask ? mask[8*i +: 8] : 8'hFF;
            b   = window_next[pos[IDX_W-1:0]];
            if (LEN_W'(i) < len) begin
                if ((p & m) != (b & m)) begin
                    hit = 1'b0;
                end
            end
        end
    end

endmodule

FILE: src/masked_byte_pattern_search_top.sv
// Top level of the masked byte pattern search: configuration, match tracking and output words.
//
//   Channel | Direction | Handshake          | Payload
//   s_      | in        | s_valid / s_ready  | in_word_t  {data_byte, last_byte}
//   m_      | out       | m_valid / m_ready  | out_word_t {found, match_address}
//   cfg_    | in        | cfg_we             | cfg_addr (register index), cfg_wdata
//
// One byte is taken every cycle while the output side drains; the compare of the
// whole window and the match bookkeeping fit in the cycle that accepts the byte.
// A result word passes the middle stage and then the output register after its last
// byte is accepted: the match record is taken into the middle stage as the byte is
// accepted, and the base address add goes into the output register from there.
// Reset is synchronous, active low, and clears the configuration and the region state.
// When the output register is full and not taken, both stages hold and s_ready drops.
`timescale 1ns / 1ps

module masked_byte_pattern_search_top #(
    parameter int PATTERN_MAX = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  mbps_pkg::in_word_t                  s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output mbps_pkg::out_word_t                 m_data,
    input  logic                                cfg_we,
    input  logic [mbps_pkg::CFG_INDEX_W-1:0]    cfg_addr,
    input  logic [mbps_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
    import mbps_pkg::*;

    localparam int LEN_W = $clog2(PATTERN_MAX + 1);

    // Configuration registers
    logic [CFG_DATA_W-1:0] pattern_low_reg, pattern_high_reg;
    logic [CFG_DATA_W-1:0] mask_low_reg, mask_high_reg;
    logic [LEN_CFG_W-1:0]  pattern_length_reg;
    logic                  use_mask_reg;
    logic                  search_backward_reg;
    logic [ADDR_W-1:0]     region_base_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pattern_low_reg     <= '0;
            pattern_high_reg    <= '0;
            mask_low_reg        <= '0;
            mask_high_reg       <= '0;
            pattern_length_reg  <= LEN_CFG_W'(1);
            use_mask_reg        <= 1'b0;
            search_backward_reg <= 1'b0;
            region_base_reg     <= '0;
        end else if (cfg_we) begin
            case (cfg_index_t'(cfg_addr))
                REG_PATTERN_LOW:     pattern_low_reg     <= cfg_wdata;
                REG_PATTERN_HIGH:    pattern_high_reg    <= cfg_wdata;
                REG_MASK_LOW:        mask_low_reg        <= cfg_wdata;
                REG_MASK_HIGH:       mask_high_reg       <= cfg_wdata;
                REG_PATTERN_LENGTH:  pattern_length_reg  <= cfg_wdata[LEN_CFG_W-1:0];
                REG_USE_MASK:        use_mask_reg        <= cfg_wdata[0];
                REG_SEARCH_BACKWARD: search_backward_reg <= cfg_wdata[0];
                REG_REGION_BASE:     region_base_reg     <= cfg_wdata[ADDR_W-1:0];
                default: ;
            endcase
        end
    end

    // Effective pattern length, clamped to 1..PATTERN_MAX.
    logic [LEN_W-1:0] len_eff;
    logic [LEN_W-1:0] len_m1;

    always_comb begin
        if (pattern_length_reg == '0) begin
            len_eff = LEN_W'(1);
        end else if (pattern_length_reg > LEN_CFG_W'(PATTERN_MAX)) begin
            len_eff = LEN_W'(PATTERN_MAX);
        end else begin
            len_eff = LEN_W'(pattern_length_reg);
        end
        len_m1 = len_eff - LEN_W'(1);
    end

    // Handshake and pipeline control
    logic stall;
    logic accept;

    assign stall   = m_valid && !m_ready;
    assign s_ready = !stall;
    assign accept  = s_valid && s_ready;

    logic hit;

    mbps_match #(
        .PATTERN_MAX (PATTERN_MAX),
        .LEN_W       (LEN_W)
    ) u_match (
        .aclk      (aclk),
        .shift_en  (accept),
        .data_byte (s_data.data_byte),
        .pattern   ({pattern_high_reg, pattern_low_reg}),
        .mask      ({mask_high_reg, mask_low_reg}),
        .use_mask  (use_mask_reg),
        .len       (len_eff),
        .hit       (hit)
    );

    // Region state
    logic [ADDR_W-1:0] bytes_seen_reg, bytes_seen_next;
    logic              have_match_reg, have_match_next;
    logic [ADDR_W-1:0] match_offset_reg, match_offset_next;

    logic              seen_sat;
    logic              window_full;
    logic [ADDR_W-1:0] cand_offset;
    logic              take_hit;

    // With the byte counted, the window is full once bytes_seen >= len-1 before
    // the increment; a saturated count is always past any pattern length.
    assign seen_sat    = &bytes_seen_reg;
    assign window_full = bytes_seen_reg >= ADDR_W'(len_m1);
    assign cand_offset = bytes_seen_reg - ADDR_W'(seen_sat ? len_eff : len_m1);
    assign take_hit    = hit && window_full && (search_backward_reg || !have_match_reg);

    always_comb begin
        bytes_seen_next   = seen_sat ? bytes_seen_reg : bytes_seen_reg + ADDR_W'(1);
        have_match_next   = have_match_reg || take_hit;
        match_offset_next = take_hit ? cand_offset : match_offset_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bytes_seen_reg   <= '0;
            have_match_reg   <= 1'b0;
            match_offset_reg <= '0;
        end else if (accept) begin
            if (s_data.last_byte) begin
                bytes_seen_reg   <= '0;
                have_match_reg   <= 1'b0;
                match_offset_reg <= '0;
            end else begin
                bytes_seen_reg   <= bytes_seen_next;
                have_match_reg   <= have_match_next;
                match_offset_reg <= match_offset_next;
            end
        end
    end

    // Middle stage: the match record of a finished region.
    logic              mid_valid_reg;
    logic              mid_found_reg;
    logic [ADDR_W-1:0] mid_offset_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mid_valid_reg <= 1'b0;
        end else if (!stall) begin
            mid_valid_reg <= accept && s_data.last_byte;
        end
    end

    always_ff @(posedge aclk) begin
        if (!stall && accept && s_data.last_byte) begin
            mid_found_reg  <= have_match_next;
            mid_offset_reg <= match_offset_next;
        end
    end

    // Output register
    logic      m_valid_reg;
    out_word_t m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (!stall) begin
            m_valid_reg <= mid_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!stall && mid_valid_reg) begin
            m_data_reg.found         <= mid_found_reg;
            m_data_reg.match_address <= mid_found_reg ? region_base_reg + mid_offset_reg
                                                      : '0;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Checks

    assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_data.last_byte |=> bytes_seen_reg == '0 && !have_match_reg)
        else $error("region state not cleared after the last byte");

    assert property (@(posedge aclk) disable iff (!aresetn)
        have_match_reg |-> bytes_seen_reg != '0)
        else $error("match recorded with no bytes seen");

    assert property (@(posedge aclk) disable iff (!aresetn)
        mid_valid_reg && !stall |=> m_valid_reg)
        else $error("finished region lost between stages");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_data_reg.found |-> m_data_reg.match_address == '0)
        else $error("address given without a match");

    assert property (@(posedge aclk) disable iff (!aresetn)
        accept && !s_data.last_byte && !seen_sat |=> bytes_seen_reg != '0)
        else $error("byte count failed to advance");

endmodule
